// File: rtl/tmcw_pkg.sv
// Package for the text mode console writer: operation and stream codes,
// default geometry and the story colour map. No dependencies.
package tmcw_pkg;

    localparam int DEF_SCREEN_COLS = 80;
    localparam int DEF_SCREEN_ROWS = 25;

    localparam logic [1:0] OP_STREAM = 2'd0;
    localparam logic [1:0] OP_COLOUR = 2'd1;
    localparam logic [1:0] OP_CURSOR = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_STYLE = 2'd1;
    localparam logic [1:0] ESC_FONT  = 2'd2;

    localparam logic [7:0] CH_STYLE   = 8'd1;
    localparam logic [7:0] CH_FONT    = 8'd2;
    localparam logic [7:0] CH_INDENT  = 8'd3;
    localparam logic [7:0] CH_GAP     = 8'd4;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [7:0] BLANK_ATTR = 8'h17;
    localparam logic [3:0] INTENSE    = 4'h8;

    localparam int STYLE_REVERSE = 0;
    localparam int STYLE_BOLD    = 1;
    localparam int STYLE_EMPH    = 2;

    function automatic logic [3:0] map_colour(input logic [3:0] c);
        logic [3:0] m;
        case (c)
            4'd2:    m = 4'd0;
            4'd6:    m = 4'd1;
            4'd4:    m = 4'd2;
            4'd8:    m = 4'd3;
            4'd3:    m = 4'd4;
            4'd7:    m = 4'd5;
            4'd5:    m = 4'd14;
            4'd9:    m = 4'd15;
            default: m = 4'd7;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/text_mode_console_writer_top.sv
// Text mode console writer: cell store sequencer around one cell RAM; needs tmcw_pkg,
// tmcw_ram and tmcw_attr. A character writes one cell, an indent three spaces, a gap two;
// a scrolling newline copies the rows up and fills the last row with spaces, at one cell
// a cycle. One transaction in work: no new input is taken until the last result is loaded
// into the output register. Reset: store cleared to blanks, o_in_ready low.
module text_mode_console_writer_top #(
    parameter int SCREEN_COLS = tmcw_pkg::DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = tmcw_pkg::DEF_SCREEN_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_code,
    input  logic [3:0] i_fore_colour,
    input  logic [3:0] i_back_colour,
    input  logic [4:0] i_row,
    input  logic [6:0] i_col,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_cell_char,
    output logic [7:0] o_cell_attr,
    output logic [4:0] o_cursor_row,
    output logic [6:0] o_cursor_col,
    output logic [7:0] o_attr_now
);

    localparam int STORE_ROWS = SCREEN_ROWS + 1;
    localparam int DEPTH      = SCREEN_COLS * STORE_ROWS;
    localparam int COPY_N     = SCREEN_COLS * SCREEN_ROWS;
    localparam int AW         = $clog2(DEPTH);
    localparam int KW         = $clog2(DEPTH + 1);
    localparam int ROW_W      = ($clog2(STORE_ROWS + 1) > 5) ? $clog2(STORE_ROWS + 1) : 5;
    localparam int COL_W      = ($clog2(SCREEN_COLS + 2) > 7) ? $clog2(SCREEN_COLS + 2) : 7;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PUT   = 3'd2;
    localparam logic [2:0] S_COPY  = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [KW-1:0]    r_k, n_k;
    logic             r_pend, n_pend;
    logic [AW-1:0]    r_waddr, n_waddr;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [3:0]       r_fg, n_fg;
    logic [3:0]       r_bg, n_bg;
    logic [7:0]       r_style, n_style;
    logic [7:0]       r_attr, n_attr;
    logic [1:0]       r_esc, n_esc;
    logic [1:0]       r_cnt, n_cnt;
    logic [7:0]       r_char, n_char;
    logic [7:0]       r_rd_char, n_rd_char;
    logic [7:0]       r_rd_attr, n_rd_attr;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_o_char, r_o_attr, r_o_attr_now;
    logic [4:0]       r_o_row;
    logic [6:0]       r_o_col;
    logic             load_out;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [15:0]      mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [15:0]      mem_rdata;

    logic             cur_ok;
    logic [AW-1:0]    cur_idx;
    logic             rd_ok;
    logic [AW-1:0]    rd_idx;
    logic [ROW_W:0]   row_inc;

    tmcw_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tmcw_attr u_attr (
        .i_fg    (n_fg),
        .i_bg    (n_bg),
        .i_style (n_style),
        .o_attr  (n_attr)
    );

    always_comb begin
        cur_ok  = (r_col != '0) && (32'(r_col) <= SCREEN_COLS) &&
                  (r_row != '0) && (32'(r_row) <= STORE_ROWS);
        cur_idx = AW'((32'(r_row) - 32'd1) * SCREEN_COLS + 32'(r_col) - 32'd1);
        rd_ok   = (i_col != '0) && (32'(i_col) <= SCREEN_COLS) &&
                  (i_row != '0) && (32'(i_row) <= STORE_ROWS);
        rd_idx  = AW'((32'(i_row) - 32'd1) * SCREEN_COLS + 32'(i_col) - 32'd1);
        row_inc = {1'b0, r_row} + 1'b1;
    end

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_pend      = r_pend;
        n_waddr     = r_waddr;
        n_row       = r_row;
        n_col       = r_col;
        n_fg        = r_fg;
        n_bg        = r_bg;
        n_style     = r_style;
        n_esc       = r_esc;
        n_cnt       = r_cnt;
        n_char      = r_char;
        n_rd_char   = r_rd_char;
        n_rd_attr   = r_rd_attr;
        n_out_valid = r_out_valid && !i_out_ready;
        load_out    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_k[AW-1:0];
                mem_wdata = {tmcw_pkg::BLANK_ATTR, tmcw_pkg::CH_SPACE};
                if (r_k == KW'(DEPTH - 1)) begin
                    n_k     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rd_char = '0;
                    n_rd_attr = '0;
                    n_state   = S_DONE;
                    case (i_operation)
                        tmcw_pkg::OP_STREAM: begin
                            if (r_esc == tmcw_pkg::ESC_STYLE) begin
                                n_esc   = tmcw_pkg::ESC_NONE;
                                n_style = i_code;
                            end else if (r_esc == tmcw_pkg::ESC_FONT) begin
                                n_esc = tmcw_pkg::ESC_NONE;
                            end else begin
                                case (i_code)
                                    tmcw_pkg::CH_STYLE: n_esc = tmcw_pkg::ESC_STYLE;
                                    tmcw_pkg::CH_FONT:  n_esc = tmcw_pkg::ESC_FONT;
                                    tmcw_pkg::CH_INDENT: begin
                                        n_cnt   = 2'd3;
                                        n_char  = tmcw_pkg::CH_SPACE;
                                        n_state = S_PUT;
                                    end
                                    tmcw_pkg::CH_GAP: begin
                                        n_cnt   = 2'd2;
                                        n_char  = tmcw_pkg::CH_SPACE;
                                        n_state = S_PUT;
                                    end
                                    tmcw_pkg::CH_NEWLINE: begin
                                        n_col = COL_W'(1);
                                        if (32'(row_inc) > SCREEN_ROWS) begin
                                            n_k     = '0;
                                            n_pend  = 1'b0;
                                            n_state = S_COPY;
                                        end else begin
                                            n_row = row_inc[ROW_W-1:0];
                                        end
                                    end
                                    default: begin
                                        n_cnt   = 2'd1;
                                        n_char  = i_code;
                                        n_state = S_PUT;
                                    end
                                endcase
                            end
                        end
                        tmcw_pkg::OP_COLOUR: begin
                            n_fg = i_fore_colour;
                            n_bg = i_back_colour;
                        end
                        tmcw_pkg::OP_CURSOR: begin
                            n_row = (32'(i_row) > STORE_ROWS) ? ROW_W'(STORE_ROWS)
                                                              : ROW_W'(i_row);
                            n_col = (32'(i_col) > SCREEN_COLS + 1) ? COL_W'(SCREEN_COLS + 1)
                                                                   : COL_W'(i_col);
                        end
                        tmcw_pkg::OP_READ: begin
                            if (rd_ok) begin
                                mem_re    = 1'b1;
                                mem_raddr = rd_idx;
                                n_state   = S_READ;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_PUT: begin
                if (cur_ok) begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_idx;
                    mem_wdata = {r_attr, r_char};
                end
                if (32'(r_col) < SCREEN_COLS + 1) begin
                    n_col = r_col + 1'b1;
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == 2'd1) begin
                    n_state = S_DONE;
                end
            end
            S_COPY: begin
                mem_re    = (r_k != KW'(COPY_N));
                mem_raddr = AW'(32'(r_k) + SCREEN_COLS);
                mem_we    = r_pend;
                mem_waddr = r_waddr;
                mem_wdata = mem_rdata;
                n_pend    = mem_re;
                if (mem_re) begin
                    n_waddr = r_k[AW-1:0];
                    n_k     = r_k + 1'b1;
                end else if (!r_pend) begin
                    n_k     = '0;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(COPY_N + 32'(r_k));
                mem_wdata = {r_attr, tmcw_pkg::CH_SPACE};
                if (r_k == KW'(SCREEN_COLS - 1)) begin
                    n_k     = '0;
                    n_state = S_DONE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_READ: begin
                n_rd_char = mem_rdata[7:0];
                n_rd_attr = mem_rdata[15:8];
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_k         <= '0;
            r_pend      <= 1'b0;
            r_row       <= ROW_W'(24);
            r_col       <= COL_W'(1);
            r_fg        <= 4'd10;
            r_bg        <= 4'd6;
            r_style     <= '0;
            r_attr      <= tmcw_pkg::BLANK_ATTR;
            r_esc       <= tmcw_pkg::ESC_NONE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_pend      <= n_pend;
            r_row       <= n_row;
            r_col       <= n_col;
            r_fg        <= n_fg;
            r_bg        <= n_bg;
            r_style     <= n_style;
            r_attr      <= n_attr;
            r_esc       <= n_esc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr   <= n_waddr;
        r_char    <= n_char;
        r_rd_char <= n_rd_char;
        r_rd_attr <= n_rd_attr;
        if (load_out) begin
            r_o_char     <= r_rd_char;
            r_o_attr     <= r_rd_attr;
            r_o_row      <= r_row[4:0];
            r_o_col      <= r_col[6:0];
            r_o_attr_now <= r_attr;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cell_char  = r_o_char;
    assign o_cell_attr  = r_o_attr;
    assign o_cursor_row = r_o_row;
    assign o_cursor_col = r_o_col;
    assign o_attr_now   = r_o_attr_now;

endmodule

// File: rtl/tmcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2080
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tmcw_attr.sv
// Attribute builder: maps story colours, applies reverse, bold and emphasis.
// Depends on tmcw_pkg.
module tmcw_attr (
    input  logic [3:0] i_fg,
    input  logic [3:0] i_bg,
    input  logic [7:0] i_style,
    output logic [7:0] o_attr
);

    logic [3:0] fg_map;
    logic [3:0] bg_map;
    logic [3:0] f;
    logic [3:0] b;

    always_comb begin
        fg_map = tmcw_pkg::map_colour(i_fg);
        bg_map = tmcw_pkg::map_colour(i_bg);
        if (i_style[tmcw_pkg::STYLE_REVERSE]) begin
            f = bg_map;
            b = fg_map;
        end else begin
            f = fg_map;
            b = bg_map;
        end
        if (i_style[tmcw_pkg::STYLE_BOLD]) begin
            f = f | tmcw_pkg::INTENSE;
        end
        if (i_style[tmcw_pkg::STYLE_EMPH]) begin
            b = b | tmcw_pkg::INTENSE;
        end
        o_attr = {b, f};
    end

endmodule

// File: rtl/tmcw_checker.sv
// Port-level checker for the text mode console writer, bound to the top level.
// Depends on text_mode_console_writer_top only through the bind.
module tmcw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_cell_char,
    input logic [6:0] o_cursor_col
);

    logic [1:0] r_open;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else if (in_acc && !out_acc) begin
            r_open <= r_open + 1'b1;
        end else if (out_acc && !in_acc) begin
            r_open <= r_open - 1'b1;
        end
    end

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input taken while a transaction is in work");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_open == 2'd2) |-> !o_in_ready)
        else $error("input ready with a result waiting and one in work");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_open == 2'd0) |-> !o_out_valid)
        else $error("result shown with no open transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_cell_char) && $stable(o_cursor_col)))
        else $error("stalled result changed");

endmodule

bind text_mode_console_writer_top tmcw_checker u_tmcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_cell_char  (o_cell_char),
    .o_cursor_col (o_cursor_col)
);
